// ----- rtl/core/wft_pkg.sv -----
package wft_pkg;

   // Fixed field widths of the stream beats
   localparam int VALUE_W     = 10;
   localparam int COUNT_OUT_W = 10;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 16;

   // Request kinds carried on req_tuser
   localparam logic KIND_ADD    = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

endpackage

// ----- rtl/core/wft_ram.sv -----
module wft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/wft_step_unit.sv -----
module wft_step_unit #(
   parameter int WIDTH = 11
) (
   input  logic [WIDTH-1:0] operand,
   input  logic             decrement,
   output logic [WIDTH-1:0] result,
   output logic             result_zero
);

   // Shared increment/decrement with zero detect on the result
   always_comb begin
      if (decrement) begin
         result = operand - WIDTH'(1);
      end else begin
         result = operand + WIDTH'(1);
      end
      result_zero = (result == '0);
   end

endmodule

// ----- rtl/core/window_mode_frequency_tracker_core.sv -----
// Window mode frequency tracker.
// Keeps a multiset of values 0..VALUES-1. Each request beat adds (req_tuser = 0)
// or removes (req_tuser = 1) the value in req_tdata[9:0]. Every request gives
// exactly one response beat: rsp_tdata[9:0] is the highest count held by any
// value after the request, rsp_tuser is 1 when the request was ignored (adding
// a value already at MAX_COUNT, removing an absent value, value out of range).
// A valid request steps through accept, count read, histogram update of the
// old count, histogram update of the new count and response load, skipping
// the new count's update when a removal takes the count to zero; an ignored
// one goes from accept through the count read (not when out of range) to the
// response load. The steps form a read-then-write sequence on the count and
// histogram memories (registered reads), which share one increment/decrement
// unit. req_tready is high only while idle. After reset the block sweeps both
// memories to zero, one entry per cycle, over max(VALUES, MAX_COUNT+1) entries
// (1024 by default) with req_tready low. The response sits in an output
// register: while the receiver stalls, the next request is accepted and
// processed, and waits in the final step until the register frees.
module window_mode_frequency_tracker_core
   import wft_pkg::*;
#(
   parameter int VALUES    = 1024,
   parameter int MAX_COUNT = 1023
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [9:0] value, rest zero
   input  logic                  req_tuser,  // [0] kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [9:0] max_count, rest zero
   output logic                  rsp_tuser   // [0] error
);

   localparam int CNT_W  = $clog2(MAX_COUNT + 1);
   localparam int VIDX_W = $clog2(VALUES);
   localparam int HIST_W = $clog2(VALUES + 1);
   localparam int W      = (CNT_W > HIST_W) ? CNT_W : HIST_W;
   localparam int CLR_N  = (VALUES > MAX_COUNT + 1) ? VALUES : MAX_COUNT + 1;
   localparam int CLR_W  = $clog2(CLR_N);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_CNT  = 3'd2;
   localparam logic [2:0] S_H0   = 3'd3;
   localparam logic [2:0] S_H1   = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [CLR_W-1:0]       clr_ff, clr_in;
   logic                   kind_ff, kind_in;
   logic [VIDX_W-1:0]      vaddr_ff, vaddr_in;
   logic [CNT_W-1:0]       c_ff, c_in;
   logic [CNT_W-1:0]       c2_ff, c2_in;
   logic [CNT_W-1:0]       highest_ff, highest_in;
   logic                   err_ff, err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_OUT_W-1:0] rsp_max_ff, rsp_max_in;
   logic                   rsp_err_ff, rsp_err_in;

   logic [31:0]            req_value_wide;
   logic [31:0]            highest_wide;
   logic [VIDX_W-1:0]      req_vaddr;
   logic                   out_of_range;

   logic                   cnt_wr_en;
   logic [VIDX_W-1:0]      cnt_wr_addr;
   logic [CNT_W-1:0]       cnt_wr_data;
   logic [CNT_W-1:0]       cnt_rd_data;

   logic                   hist_wr_en;
   logic [CNT_W-1:0]       hist_wr_addr;
   logic [HIST_W-1:0]      hist_wr_data;
   logic [CNT_W-1:0]       hist_rd_addr;
   logic [HIST_W-1:0]      hist_rd_data;

   logic [W-1:0]           step_operand;
   logic                   step_decrement;
   logic [W-1:0]           step_result;
   logic                   step_zero;

   // Decode request value
   assign req_value_wide = 32'(req_tdata[VALUE_W-1:0]);
   assign req_vaddr      = req_value_wide[VIDX_W-1:0];
   assign out_of_range   = (req_value_wide >= 32'(VALUES));
   assign highest_wide   = 32'(highest_ff);

   wft_ram #(
      .WIDTH (CNT_W),
      .DEPTH (VALUES)
   ) u_counts (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (req_vaddr),
      .rd_data (cnt_rd_data)
   );

   wft_ram #(
      .WIDTH (HIST_W),
      .DEPTH (MAX_COUNT + 1)
   ) u_histogram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   wft_step_unit #(
      .WIDTH (W)
   ) u_step (
      .operand     (step_operand),
      .decrement   (step_decrement),
      .result      (step_result),
      .result_zero (step_zero)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      kind_in      = kind_ff;
      vaddr_in     = vaddr_ff;
      c_in         = c_ff;
      c2_in        = c2_ff;
      highest_in   = highest_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_max_in   = rsp_max_ff;
      rsp_err_in   = rsp_err_ff;

      cnt_wr_en    = 1'b0;
      cnt_wr_addr  = vaddr_ff;
      cnt_wr_data  = c2_ff;
      hist_wr_en   = 1'b0;
      hist_wr_addr = c_ff;
      hist_wr_data = step_result[HIST_W-1:0];
      hist_rd_addr = c2_ff;

      step_operand   = '0;
      step_decrement = 1'b0;

      case (state_ff)
         S_CLR: begin
            // Sweep both memories to zero
            cnt_wr_en    = 1'b1;
            cnt_wr_addr  = clr_ff[VIDX_W-1:0];
            cnt_wr_data  = '0;
            hist_wr_en   = 1'b1;
            hist_wr_addr = clr_ff[CNT_W-1:0];
            hist_wr_data = '0;
            clr_in       = clr_ff + CLR_W'(1);
            if (clr_ff == CLR_W'(CLR_N - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // Take a request; count read is issued at this edge
            if (req_tvalid) begin
               kind_in  = req_tuser;
               vaddr_in = req_vaddr;
               err_in   = out_of_range;
               state_in = out_of_range ? S_DONE : S_CNT;
            end
         end
         S_CNT: begin
            // Check the count, form the new count, read its histogram entry
            step_operand   = W'(cnt_rd_data);
            step_decrement = (kind_ff == KIND_REMOVE);
            c_in           = cnt_rd_data;
            c2_in          = step_result[CNT_W-1:0];
            hist_rd_addr   = cnt_rd_data;
            if (kind_ff == KIND_ADD) begin
               err_in = (cnt_rd_data == CNT_W'(MAX_COUNT));
            end else begin
               err_in = (cnt_rd_data == '0);
            end
            if (err_in) begin
               state_in = S_DONE;
            end else begin
               state_in = S_H0;
               if (kind_ff == KIND_ADD && step_result[CNT_W-1:0] > highest_ff) begin
                  highest_in = step_result[CNT_W-1:0];
               end
            end
         end
         S_H0: begin
            // Drop one from the old count's entry, store the new count
            step_operand   = W'(hist_rd_data);
            step_decrement = 1'b1;
            hist_wr_en     = (kind_ff == KIND_REMOVE) || (c_ff != '0);
            hist_wr_addr   = c_ff;
            cnt_wr_en      = 1'b1;
            hist_rd_addr   = c2_ff;
            if (kind_ff == KIND_REMOVE && c_ff == highest_ff && step_zero) begin
               highest_in = c2_ff;
            end
            if (kind_ff == KIND_REMOVE && c2_ff == '0) begin
               state_in = S_DONE;
            end else begin
               state_in = S_H1;
            end
         end
         S_H1: begin
            // Add one to the new count's entry
            step_operand   = W'(hist_rd_data);
            step_decrement = 1'b0;
            hist_wr_en     = 1'b1;
            hist_wr_addr   = c2_ff;
            state_in       = S_DONE;
         end
         S_DONE: begin
            // Load the response once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = highest_wide[COUNT_OUT_W-1:0];
               rsp_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         highest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         err_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         highest_ff   <= highest_in;
         rsp_valid_ff <= rsp_valid_in;
         err_ff       <= err_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      vaddr_ff   <= vaddr_in;
      c_ff       <= c_in;
      c2_ff      <= c2_in;
      rsp_max_ff <= rsp_max_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_max_ff);
   assign rsp_tuser  = rsp_err_ff;

endmodule

// ----- rtl/core/wft_checker.sv -----
module wft_checker
   import wft_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // Stalled response beat keeps valid and payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   // Upper response bits stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:COUNT_OUT_W] == '0)
      else $error("response padding not zero");

   // Memory sweep keeps the block busy right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !req_tready)
      else $error("request taken during clearing sweep");

   // An accepted request keeps the block busy for the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in flight");

endmodule

bind window_mode_frequency_tracker_core wft_checker u_wft_checker (.*);
